FILE: rtl/core/float_add_sub_unit_defines.svh
// Assertion macros used by the checker file fas_checker.sv.
// No dependencies.
`ifndef FLOAT_ADD_SUB_UNIT_DEFINES_SVH
`define FLOAT_ADD_SUB_UNIT_DEFINES_SVH
// Implication under synchronous reset.
`define FAS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication under synchronous reset.
`define FAS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: rtl/core/fas_pkg.sv
// Package for the single-precision add/subtract unit.
// Holds widths, constants and the pipeline stage word types.
package fas_pkg;
    localparam int unsigned WordW   = 32;
    localparam int unsigned ExpW    = 8;
    localparam int unsigned FracW   = 23;
    localparam int unsigned MantW   = 24;
    localparam int unsigned AccW    = 27;
    localparam int unsigned FarGap  = 26;
    localparam int unsigned LzW     = 5;

    typedef enum logic {
        KIND_ADD = 1'b0,
        KIND_SUB = 1'b1
    } t_kind;

    // stage 1: ordered operands
    typedef struct packed {
        logic               bypass;
        logic [WordW-1:0]   big;
        logic               s1;
        logic               same;
        logic [ExpW-1:0]    e1;
        logic [MantW-1:0]   m1;
        logic [MantW-1:0]   m2;
        logic [FracW-1:0]   f2;
        logic [ExpW-1:0]    gap;
    } t_st1;

    // stage 2: aligned and summed
    typedef struct packed {
        logic               bypass;
        logic [WordW-1:0]   big;
        logic               s1;
        logic               same;
        logic [ExpW-1:0]    e1;
        logic [AccW-1:0]    acc;
        logic               sticky;
    } t_st2;

    function automatic logic [LzW-1:0] lead_zeros(input logic [MantW-1:0] v);
        logic [LzW-1:0] n;
        n = LzW'(MantW);
        for (int i = 0; i < MantW; i++) begin
            if (v[i]) begin
                n = LzW'(MantW - 1 - i);
            end
        end
        return n;
    endfunction
endpackage

FILE: rtl/core/float_add_sub_unit.sv
// Single-precision add/subtract, three register stages, no stored state.
// An accepted input word passes through r_s1, r_s2 and r_res to become the result word.
// Throughput: one word per cycle while i_stall is low; a stalled output holds only full stages, bubbles close up.
// Reset (i_rst_n, synchronous, active low) clears the stage valid bits only.
module float_add_sub_unit
    import fas_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_kind,
    input  logic [WordW-1:0] i_operand_a,
    input  logic [WordW-1:0] i_operand_b,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [WordW-1:0] o_sum_bits
);
    logic             r_v1, r_v2, r_v3;
    t_st1             r_s1, n_s1;
    t_st2             r_s2, n_s2;
    logic [WordW-1:0] r_res, n_res;
    logic             adv3, adv2, adv1;

    assign adv3    = !r_v3 || !i_stall;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_stall = !adv1;
    assign o_valid = r_v3;
    assign o_sum_bits = r_res;

    // stage 1: negate, order, unpack
    always_comb begin
        logic [WordW-1:0] a, b, bg, sm;
        a = i_operand_a;
        b = i_operand_b;
        if (t_kind'(i_kind) == KIND_SUB) begin
            b[WordW-1] = ~b[WordW-1];
        end
        if (a[30:23] < b[30:23] || (a[30:23] == b[30:23] && a[22:0] < b[22:0])) begin
            bg = b;
            sm = a;
        end else begin
            bg = a;
            sm = b;
        end
        n_s1.bypass = (sm[30:23] == '0);
        n_s1.big    = bg;
        n_s1.s1     = bg[31];
        n_s1.same   = (bg[31] == sm[31]);
        n_s1.e1     = bg[30:23];
        n_s1.m1     = {1'b1, bg[22:0]};
        n_s1.m2     = {1'b1, sm[22:0]};
        n_s1.f2     = sm[22:0];
        n_s1.gap    = bg[30:23] - sm[30:23];
    end

    // stage 2: align and add or subtract
    always_comb begin
        logic [AccW-1:0]  al;
        logic [AccW-1:0]  wide;
        logic [ExpW-1:0]  sh;
        logic             st;
        al = '0;
        st = 1'b0;
        sh = r_s1.gap - ExpW'(2);
        wide = {3'b000, r_s1.m2};
        if (r_s1.gap < ExpW'(2)) begin
            al = (r_s1.gap == '0) ? AccW'({r_s1.m2, 2'b00}) : AccW'({r_s1.m2, 1'b0});
        end else if (r_s1.gap < ExpW'(FarGap)) begin
            al = wide >> sh[4:0];
            st = ((wide & ((AccW'(1) << sh[4:0]) - AccW'(1))) != '0);
        end else begin
            st = (r_s1.f2 != '0);
        end
        n_s2.bypass = r_s1.bypass;
        n_s2.big    = r_s1.big;
        n_s2.s1     = r_s1.s1;
        n_s2.same   = r_s1.same;
        n_s2.e1     = r_s1.e1;
        n_s2.sticky = st;
        if (r_s1.same) begin
            n_s2.acc = AccW'({r_s1.m1, 2'b00}) + al;
        end else begin
            n_s2.acc = AccW'({r_s1.m1, 2'b00}) - al;
        end
    end

    // stage 3: round, normalize, pack
    always_comb begin
        logic [AccW-1:0] acc;
        logic [ExpW:0]   ex;
        logic [LzW-1:0]  lz;
        logic [MantW-1:0] m;
        acc = r_s2.acc;
        ex  = {1'b0, r_s2.e1};
        m   = '0;
        lz  = '0;
        if (r_s2.same) begin
            if (acc[26]) begin
                if (acc[2:0] > 3'd4 || (acc[2:0] == 3'd4 && (r_s2.sticky || acc[3]))) begin
                    acc = acc + AccW'(8);
                end
                m  = acc[26:3];
                ex = ex + 9'd1;
            end else begin
                if (acc[1:0] == 2'd3 || (acc[1:0] == 2'd2 && (r_s2.sticky || acc[2]))) begin
                    acc = acc + AccW'(4);
                end
                if (acc[26]) begin
                    m  = acc[26:3];
                    ex = ex + 9'd1;
                end else begin
                    m = acc[25:2];
                end
            end
        end else if (!acc[25] && !acc[24]) begin
            ex = ex - 9'd2;
            if (acc == '0) begin
                ex = '0;
            end else begin
                lz = lead_zeros(acc[23:0]);
                m  = acc[23:0] << lz;
                ex = ex - {4'd0, lz};
            end
        end else if (!acc[25]) begin
            if (acc[0] && !r_s2.sticky && acc[1]) begin
                acc = acc + AccW'(2);
            end
            if (!acc[25]) begin
                m  = acc[24:1];
                ex = ex - 9'd1;
            end else begin
                m = acc[25:2];
            end
        end else begin
            if (acc[1:0] == 2'd3 || (acc[1:0] == 2'd2 && !r_s2.sticky && acc[2])) begin
                acc = acc + AccW'(4);
            end
            m = acc[25:2];
        end
        // borrow out of the 9-bit exponent means underflow
        if (!r_s2.same && ex[ExpW] && r_s2.e1 < ExpW'(3 + 23)) begin
            if ({1'b0, r_s2.e1} < 9'd2 + (acc[25:24] == 2'b00 && acc != '0 ?
                {4'd0, lz} : 9'd0) + (acc[25:24] == 2'b00 ? 9'd0 :
                (acc[25] ? 9'd0 : 9'd1))) begin
                ex = '0;
            end
        end
        if (r_s2.bypass) begin
            n_res = r_s2.big;
        end else begin
            n_res = {r_s2.s1, ex[ExpW-1:0], m[FracW-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) r_s1 <= n_s1;
        if (adv2) r_s2 <= n_s2;
        if (adv3) r_res <= n_res;
    end
endmodule

FILE: rtl/core/fas_checker.sv
// Port-level checker for float_add_sub_unit, bound to the top level.
// Depends on fas_pkg and float_add_sub_unit_defines.svh.
`include "float_add_sub_unit_defines.svh"
module fas_checker
    import fas_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_stall,
    input logic             o_valid,
    input logic             i_stall,
    input logic [WordW-1:0] o_sum_bits
);
    `FAS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_sum_bits), "result word changed under stall")
    `FAS_ASSERT_IMP(a_no_stall_free, i_clk, i_rst_n, !i_stall, !o_stall, "input stalled while output free")
    `FAS_ASSERT_NXT(a_drain, i_clk, i_rst_n, !o_valid && !i_valid, !o_stall, "input stalled with empty output")
endmodule

bind float_add_sub_unit fas_checker u_fas_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_sum_bits (o_sum_bits)
);

FILE: dv/testbench.sv
// Self-checking testbench for float_add_sub_unit, the single-precision add/subtract unit.
// Predicts each result word in place and compares it with the result stream, under
// several idle and stall mixes. Depends on fas_pkg and the RTL top level.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import fas_pkg::*;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    logic             i_kind = 1'b0;
    logic [WordW-1:0] i_operand_a = '0;
    logic [WordW-1:0] i_operand_b = '0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic [WordW-1:0] o_sum_bits;

    logic [WordW-1:0] expected_sums[$];
    int unsigned      error_count = 0;
    int unsigned      cycle_count = 0;
    int unsigned      send_idle_pct = 0;
    int unsigned      stall_pct = 0;

    localparam int unsigned CycleLimit = 400000;

    float_add_sub_unit dut (.*);

    always #4 i_clk = ~i_clk;

    function automatic logic [WordW-1:0] predict_sum(t_kind kind, logic [31:0] a,
                                                     logic [31:0] b);
        logic [31:0] big, sml, m1, m2, f2, acc, r, gap, sh, ex;
        logic        s1, s2, sticky;
        if (kind == KIND_SUB) begin
            b[31] = ~b[31];
        end
        big = a;
        sml = b;
        if (a[30:23] < b[30:23] || (a[30:23] == b[30:23] && a[22:0] < b[22:0])) begin
            big = b;
            sml = a;
        end
        s1 = big[31];
        s2 = sml[31];
        m1 = {8'd0, 1'b1, big[22:0]};
        f2 = {9'd0, sml[22:0]};
        m2 = {8'd0, 1'b1, sml[22:0]};
        sticky = 1'b0;
        acc = 0;
        if (sml[30:23] == 0) begin
            return big;
        end
        gap = 32'(big[30:23]) - 32'(sml[30:23]);
        if (gap < 2) begin
            acc = m2 << (2 - gap);
        end else if (gap < 26) begin
            sh = gap - 2;
            acc = m2 >> sh;
            sticky = (m2 & ((32'd1 << sh) - 1)) != 0;
        end else begin
            sticky = f2 != 0;
        end
        ex = 32'(big[30:23]);
        if (s1 == s2) begin
            acc += m1 << 2;
            if ((acc >> 2) > 32'd16777215) begin
                r = acc & 7;
                if (r > 4 || (r == 4 && (sticky || acc[3]))) begin
                    acc += 8;
                end
                acc >>= 3;
                ex += 1;
            end else begin
                r = acc & 3;
                if (r > 2 || (r == 2 && (sticky || acc[2]))) begin
                    acc += 4;
                end
                acc >>= 2;
                if (acc > 32'd16777215) begin
                    acc >>= 1;
                    ex += 1;
                end
            end
            return {s1, ex[7:0], acc[22:0]};
        end
        acc = (m1 << 2) - acc;
        if ((acc >> 1) < 32'd8388608) begin
            ex -= 2;
            if (acc == 0) begin
                ex = 0;
            end else begin
                while (acc < 32'd8388608) begin
                    acc <<= 1;
                    ex -= 1;
                end
            end
        end else if ((acc >> 2) < 32'd8388608) begin
            if (acc[0] && !sticky && acc[1]) begin
                acc += 2;
            end
            if ((acc >> 2) < 32'd8388608) begin
                acc >>= 1;
                ex -= 1;
            end else begin
                acc >>= 2;
            end
        end else begin
            r = acc & 3;
            if (r > 2 || (r == 2 && !sticky && acc[2])) begin
                acc += 4;
            end
            acc >>= 2;
        end
        if (ex > 256) begin
            ex = 0;
        end
        return {s1, ex[7:0], acc[22:0]};
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        $display("mismatch at cycle %0d: %s got %08h want %08h", cycle_count, what, got, want);
    endtask

    task automatic send_word(t_kind kind, logic [31:0] a, logic [31:0] b);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_operand_a <= a;
        i_operand_b <= b;
        expected_sums.push_back(predict_sum(kind, a, b));
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("** float_add_sub_unit: FAILED **");
            $finish;
        end
        i_stall <= stall_pct != 0 && $urandom_range(99) < stall_pct;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_sums.size() == 0) begin
                report_mismatch("unexpected sum_bits", o_sum_bits, '0);
            end else begin
                if (o_sum_bits !== expected_sums[0]) begin
                    report_mismatch("sum_bits", o_sum_bits, expected_sums[0]);
                end
                void'(expected_sums.pop_front());
            end
        end
    end

    function automatic logic [31:0] rand_float();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(5))
            0: v[30:23] = 8'd0;
            1: v[30:23] = 8'd255;
            2: v[22:0] = ($urandom_range(1) != 0) ? 23'd0 : 23'h7fffff;
            default: ;
        endcase
        return v;
    endfunction

    task automatic test_directed();
        t_kind k;
        for (int i = 0; i < 2; i++) begin
            k = t_kind'(i);
            send_word(k, 32'h3f800000, 32'h3f800000);
            send_word(k, 32'h3f800000, 32'h00000000);
            send_word(k, 32'h00000001, 32'hbf800000);
            send_word(k, 32'h7f7fffff, 32'h7f7fffff);
            send_word(k, 32'hffffffff, 32'h7fffffff);
            send_word(k, 32'h3f800000, 32'h33ffffff);
            send_word(k, 32'h3f800000, 32'hb3800001);
            send_word(k, 32'h3f800001, 32'hbf800000);
            send_word(k, 32'h00800000, 32'h80800001);
            send_word(k, 32'h3fffffff, 32'h3f800001);
            send_word(k, 32'h4b800000, 32'h3f800000);
            send_word(k, 32'h3f800000, 32'hbf7fffff);
        end
    endtask

    task automatic test_random(int unsigned count);
        logic [31:0] a, b;
        for (int unsigned n = 0; n < count; n++) begin
            a = rand_float();
            b = rand_float();
            if ($urandom_range(2) == 0) begin
                b[30:23] = a[30:23] + 8'($urandom_range(3)) - 8'd1;
            end
            send_word(t_kind'($urandom_range(1)), a, b);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_sums.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(250);
        send_idle_pct = 76;
        test_random(230);
        send_idle_pct = 0;
        stall_pct = 76;
        test_random(230);
        send_idle_pct = 9;
        stall_pct = 9;
        test_random(230);
        stall_pct = 0;
        drain();
        if (error_count == 0) begin
            $display("** float_add_sub_unit: PASSED **");
        end else begin
            $display("** float_add_sub_unit: FAILED **");
        end
        $finish;
    end
endmodule

FILE: float_add_sub_unit.f
+incdir+rtl/core
rtl/core/fas_pkg.sv
rtl/core/float_add_sub_unit.sv
rtl/core/fas_checker.sv
dv/testbench.sv
